// File: hw/rtl/iht_pkg.sv
package iht_pkg;

    // ICMPv4 message types
    localparam logic [7:0] V4_ECHO_REPLY   = 8'd0;
    localparam logic [7:0] V4_DEST_UNREACH = 8'd3;
    localparam logic [7:0] V4_ECHO_REQUEST = 8'd8;
    localparam logic [7:0] V4_TIME_EXCEED  = 8'd11;
    localparam logic [7:0] V4_PARAM_PROB   = 8'd12;

    // ICMPv6 message types
    localparam logic [7:0] V6_DEST_UNREACH = 8'd1;
    localparam logic [7:0] V6_PKT_TOO_BIG  = 8'd2;
    localparam logic [7:0] V6_TIME_EXCEED  = 8'd3;
    localparam logic [7:0] V6_PARAM_PROB   = 8'd4;
    localparam logic [7:0] V6_ECHO_REQUEST = 8'd128;
    localparam logic [7:0] V6_ECHO_REPLY   = 8'd129;

    // incoming ICMPv4 destination unreachable codes
    localparam logic [7:0] V4_IN_NET        = 8'd0;
    localparam logic [7:0] V4_IN_HOST       = 8'd1;
    localparam logic [7:0] V4_IN_PROTO      = 8'd2;
    localparam logic [7:0] V4_IN_PORT       = 8'd3;
    localparam logic [7:0] V4_IN_FRAG       = 8'd4;
    localparam logic [7:0] V4_IN_SRC_ROUTE  = 8'd5;
    localparam logic [7:0] V4_IN_NET_UNK    = 8'd6;
    localparam logic [7:0] V4_IN_HOST_UNK   = 8'd7;
    localparam logic [7:0] V4_IN_ISOLATED   = 8'd8;
    localparam logic [7:0] V4_IN_NET_PROHIB = 8'd9;
    localparam logic [7:0] V4_IN_HST_PROHIB = 8'd10;
    localparam logic [7:0] V4_IN_NET_TOS    = 8'd11;
    localparam logic [7:0] V4_IN_HOST_TOS   = 8'd12;
    localparam logic [7:0] V4_IN_ADMIN      = 8'd13;
    localparam logic [7:0] V4_IN_PREC_VIOL  = 8'd15;
    // incoming ICMPv4 parameter problem codes
    localparam logic [7:0] V4_IN_PP_PTR     = 8'd0;
    localparam logic [7:0] V4_IN_PP_BADLEN  = 8'd2;
    // incoming ICMPv6 destination unreachable codes
    localparam logic [7:0] V6_IN_NOROUTE    = 8'd0;
    localparam logic [7:0] V6_IN_ADMIN      = 8'd1;
    localparam logic [7:0] V6_IN_SCOPE      = 8'd2;
    localparam logic [7:0] V6_IN_ADDR       = 8'd3;
    localparam logic [7:0] V6_IN_PORT       = 8'd4;

    // ICMPv4 destination unreachable codes produced
    localparam logic [7:0] V4_UNR_HOST     = 8'd1;
    localparam logic [7:0] V4_UNR_PROTO    = 8'd2;
    localparam logic [7:0] V4_UNR_PORT     = 8'd3;
    localparam logic [7:0] V4_UNR_FRAG     = 8'd4;
    localparam logic [7:0] V4_UNR_ADMIN    = 8'd10;

    // ICMPv6 codes produced
    localparam logic [7:0] V6_UNR_NOROUTE  = 8'd0;
    localparam logic [7:0] V6_UNR_ADMIN    = 8'd1;
    localparam logic [7:0] V6_UNR_PORT     = 8'd4;
    localparam logic [7:0] V6_PTB_CODE     = 8'd0;
    localparam logic [7:0] V6_PP_HDR       = 8'd0;
    localparam logic [7:0] V6_PP_NEXTHDR   = 8'd1;
    localparam logic [7:0] V4_PP_PTR       = 8'd0;

    localparam logic [0:0] DIR_V4_TO_V6    = 1'b0;

    localparam logic [15:0] MTU_DELTA  = 16'd20;
    localparam logic [16:0] MIN_V6_MTU = 17'd1280;
    localparam logic [31:0] NEXTHDR_PTR = 32'd6;

    typedef struct packed {
        logic        accepted;
        logic [7:0]  msg_type;
        logic [7:0]  msg_code;
        logic [31:0] rest_word;
    } t_xlate;

endpackage

// File: hw/rtl/iht_map.sv
module iht_map (
    input  logic             i_action,
    input  logic [7:0]       i_msg_type,
    input  logic [7:0]       i_msg_code,
    input  logic [31:0]      i_rest_word,
    output iht_pkg::t_xlate  o_xlate
);

    logic [16:0] v4_mtu;
    logic [31:0] v6_mtu;
    logic [7:0]  v4_ptr;
    logic [7:0]  v6_ptr;
    logic        v4_ptr_ok;
    logic        v6_ptr_ok;

    // packet too big MTU adjustments
    assign v4_mtu = {1'b0, i_rest_word[15:0]} + {1'b0, iht_pkg::MTU_DELTA};
    assign v6_mtu = i_rest_word - {16'd0, iht_pkg::MTU_DELTA};

    // v4 pointer (byte 4) to v6 pointer
    always_comb begin
        v4_ptr    = 8'd0;
        v4_ptr_ok = 1'b1;
        case (i_rest_word[31:24])
            8'd0:                          v4_ptr = 8'd0;
            8'd1:                          v4_ptr = 8'd1;
            8'd2, 8'd3:                    v4_ptr = 8'd4;
            8'd8:                          v4_ptr = 8'd7;
            8'd9:                          v4_ptr = 8'd6;
            8'd12, 8'd13, 8'd14, 8'd15:    v4_ptr = 8'd8;
            8'd16, 8'd17, 8'd18, 8'd19:    v4_ptr = 8'd24;
            default:                       v4_ptr_ok = 1'b0;
        endcase
    end

    // v6 32-bit pointer to v4 pointer byte
    always_comb begin
        v6_ptr    = 8'd0;
        v6_ptr_ok = (i_rest_word[31:6] == 26'd0);
        if (i_rest_word[5:0] <= 6'd1) begin
            v6_ptr = {2'b00, i_rest_word[5:0]};
        end else if (i_rest_word[5:0] == 6'd4 || i_rest_word[5:0] == 6'd5) begin
            v6_ptr = 8'd2;
        end else if (i_rest_word[5:0] == 6'd6) begin
            v6_ptr = 8'd9;
        end else if (i_rest_word[5:0] == 6'd7) begin
            v6_ptr = 8'd8;
        end else if (i_rest_word[5:0] >= 6'd8 && i_rest_word[5:0] <= 6'd23) begin
            v6_ptr = 8'd12;
        end else if (i_rest_word[5:0] >= 6'd24 && i_rest_word[5:0] <= 6'd39) begin
            v6_ptr = 8'd16;
        end else begin
            v6_ptr_ok = 1'b0;
        end
    end

    always_comb begin
        o_xlate.accepted  = 1'b1;
        o_xlate.msg_type  = i_msg_type;
        o_xlate.msg_code  = i_msg_code;
        o_xlate.rest_word = i_rest_word;
        if (i_action == iht_pkg::DIR_V4_TO_V6[0]) begin
            case (i_msg_type)
                iht_pkg::V4_ECHO_REQUEST: o_xlate.msg_type = iht_pkg::V6_ECHO_REQUEST;
                iht_pkg::V4_ECHO_REPLY:   o_xlate.msg_type = iht_pkg::V6_ECHO_REPLY;
                iht_pkg::V4_TIME_EXCEED:  o_xlate.msg_type = iht_pkg::V6_TIME_EXCEED;
                iht_pkg::V4_DEST_UNREACH: begin
                    o_xlate.msg_type = iht_pkg::V6_DEST_UNREACH;
                    case (i_msg_code)
                        iht_pkg::V4_IN_NET, iht_pkg::V4_IN_HOST, iht_pkg::V4_IN_SRC_ROUTE,
                        iht_pkg::V4_IN_NET_UNK, iht_pkg::V4_IN_HOST_UNK,
                        iht_pkg::V4_IN_ISOLATED, iht_pkg::V4_IN_NET_TOS,
                        iht_pkg::V4_IN_HOST_TOS:
                            o_xlate.msg_code = iht_pkg::V6_UNR_NOROUTE;
                        iht_pkg::V4_IN_PORT:
                            o_xlate.msg_code = iht_pkg::V6_UNR_PORT;
                        iht_pkg::V4_IN_NET_PROHIB, iht_pkg::V4_IN_HST_PROHIB,
                        iht_pkg::V4_IN_ADMIN, iht_pkg::V4_IN_PREC_VIOL:
                            o_xlate.msg_code = iht_pkg::V6_UNR_ADMIN;
                        iht_pkg::V4_IN_PROTO: begin
                            // protocol unreachable becomes next-header problem
                            o_xlate.msg_type  = iht_pkg::V6_PARAM_PROB;
                            o_xlate.msg_code  = iht_pkg::V6_PP_NEXTHDR;
                            o_xlate.rest_word = iht_pkg::NEXTHDR_PTR;
                        end
                        iht_pkg::V4_IN_FRAG: begin
                            o_xlate.msg_type  = iht_pkg::V6_PKT_TOO_BIG;
                            o_xlate.msg_code  = iht_pkg::V6_PTB_CODE;
                            o_xlate.rest_word = (v4_mtu < iht_pkg::MIN_V6_MTU) ?
                                {15'd0, iht_pkg::MIN_V6_MTU} : {15'd0, v4_mtu};
                        end
                        default: o_xlate.accepted = 1'b0;
                    endcase
                end
                iht_pkg::V4_PARAM_PROB: begin
                    o_xlate.msg_type  = iht_pkg::V6_PARAM_PROB;
                    o_xlate.msg_code  = iht_pkg::V6_PP_HDR;
                    o_xlate.rest_word = {24'd0, v4_ptr};
                    if ((i_msg_code != iht_pkg::V4_IN_PP_PTR &&
                         i_msg_code != iht_pkg::V4_IN_PP_BADLEN) || !v4_ptr_ok) begin
                        o_xlate.accepted = 1'b0;
                    end
                end
                default: o_xlate.accepted = 1'b0;
            endcase
        end else begin
            case (i_msg_type)
                iht_pkg::V6_ECHO_REQUEST: o_xlate.msg_type = iht_pkg::V4_ECHO_REQUEST;
                iht_pkg::V6_ECHO_REPLY:   o_xlate.msg_type = iht_pkg::V4_ECHO_REPLY;
                iht_pkg::V6_TIME_EXCEED:  o_xlate.msg_type = iht_pkg::V4_TIME_EXCEED;
                iht_pkg::V6_DEST_UNREACH: begin
                    o_xlate.msg_type = iht_pkg::V4_DEST_UNREACH;
                    case (i_msg_code)
                        iht_pkg::V6_IN_NOROUTE, iht_pkg::V6_IN_SCOPE, iht_pkg::V6_IN_ADDR:
                            o_xlate.msg_code = iht_pkg::V4_UNR_HOST;
                        iht_pkg::V6_IN_ADMIN: o_xlate.msg_code = iht_pkg::V4_UNR_ADMIN;
                        iht_pkg::V6_IN_PORT:  o_xlate.msg_code = iht_pkg::V4_UNR_PORT;
                        default:              o_xlate.accepted = 1'b0;
                    endcase
                end
                iht_pkg::V6_PKT_TOO_BIG: begin
                    o_xlate.msg_type  = iht_pkg::V4_DEST_UNREACH;
                    o_xlate.msg_code  = iht_pkg::V4_UNR_FRAG;
                    o_xlate.rest_word = v6_mtu;
                    if (v6_mtu[31:16] != 16'd0) begin
                        o_xlate.accepted = 1'b0;
                    end
                end
                iht_pkg::V6_PARAM_PROB: begin
                    if (i_msg_code == iht_pkg::V6_PP_NEXTHDR) begin
                        o_xlate.msg_type  = iht_pkg::V4_DEST_UNREACH;
                        o_xlate.msg_code  = iht_pkg::V4_UNR_PROTO;
                        o_xlate.rest_word = 32'd0;
                    end else begin
                        o_xlate.msg_type  = iht_pkg::V4_PARAM_PROB;
                        o_xlate.msg_code  = iht_pkg::V4_PP_PTR;
                        o_xlate.rest_word = {v6_ptr, 24'd0};
                        if (i_msg_code != iht_pkg::V6_PP_HDR || !v6_ptr_ok) begin
                            o_xlate.accepted = 1'b0;
                        end
                    end
                end
                default: o_xlate.accepted = 1'b0;
            endcase
        end
    end

endmodule

// File: hw/rtl/iht_csum.sv
module iht_csum (
    input  logic             i_action,
    input  logic [7:0]       i_msg_type,
    input  logic [7:0]       i_msg_code,
    input  logic [31:0]      i_rest_word,
    input  logic [15:0]      i_old_checksum,
    input  logic [15:0]      i_pseudo_sum,
    input  iht_pkg::t_xlate  i_xlate,
    output logic [15:0]      o_checksum
);

    logic [15:0] tc_old;
    logic [15:0] tc_new;
    logic [16:0] term_tc;
    logic [16:0] term_hi;
    logic [16:0] term_lo;
    logic [15:0] pseudo_term;
    logic [18:0] sum;
    logic [16:0] fold1;
    logic [16:0] fold2;

    assign tc_old = {i_msg_type, i_msg_code};
    assign tc_new = {i_xlate.msg_type, i_xlate.msg_code};

    // unchanged words contribute nothing
    assign term_tc = (tc_old != tc_new) ? ({1'b0, ~tc_old} + {1'b0, tc_new}) : 17'd0;
    assign term_hi = (i_rest_word[31:16] != i_xlate.rest_word[31:16]) ?
        ({1'b0, ~i_rest_word[31:16]} + {1'b0, i_xlate.rest_word[31:16]}) : 17'd0;
    assign term_lo = (i_rest_word[15:0] != i_xlate.rest_word[15:0]) ?
        ({1'b0, ~i_rest_word[15:0]} + {1'b0, i_xlate.rest_word[15:0]}) : 17'd0;

    // v4 to v6 adds the pseudo-header, v6 to v4 removes it
    assign pseudo_term = (i_action == iht_pkg::DIR_V4_TO_V6[0]) ? i_pseudo_sum : ~i_pseudo_sum;

    assign sum = {3'd0, ~i_old_checksum} + {3'd0, pseudo_term} + {2'd0, term_tc}
               + {2'd0, term_hi} + {2'd0, term_lo};
    assign fold1 = {1'b0, sum[15:0]} + {14'd0, sum[18:16]};
    assign fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};

    assign o_checksum = i_xlate.accepted ? ~fold2[15:0] : 16'd0;

endmodule

// File: hw/rtl/icmp_header_translate.sv
// ICMPv4 <-> ICMPv6 header translator.
// Path from an accepted item to its result: the input register, then mapping and
// checksum logic into the result register.
// Throughput: one item per cycle; busy is never raised and the receiver cannot stall.
// Reset (synchronous, active low) clears the valid flags; no result strobes after it.
module icmp_header_translate (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [7:0]  i_msg_type,
    input  logic [7:0]  i_msg_code,
    input  logic [31:0] i_rest_word,
    input  logic [15:0] i_old_checksum,
    input  logic [15:0] i_pseudo_sum,
    output logic        o_strobe,
    output logic        o_accepted,
    output logic [7:0]  o_out_type,
    output logic [7:0]  o_out_code,
    output logic [31:0] o_out_rest_word,
    output logic [15:0] o_out_checksum
);

    logic        r_in_vld;
    logic        r_action;
    logic [7:0]  r_msg_type;
    logic [7:0]  r_msg_code;
    logic [31:0] r_rest_word;
    logic [15:0] r_old_checksum;
    logic [15:0] r_pseudo_sum;

    logic        r_strobe;
    logic        r_accepted;
    logic [7:0]  r_out_type;
    logic [7:0]  r_out_code;
    logic [31:0] r_out_rest_word;
    logic [15:0] r_out_checksum;

    iht_pkg::t_xlate xlate;
    logic [15:0]     n_checksum;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_in_vld <= start;
            r_strobe <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action       <= i_action;
        r_msg_type     <= i_msg_type;
        r_msg_code     <= i_msg_code;
        r_rest_word    <= i_rest_word;
        r_old_checksum <= i_old_checksum;
        r_pseudo_sum   <= i_pseudo_sum;
    end

    iht_map u_map (
        .i_action    (r_action),
        .i_msg_type  (r_msg_type),
        .i_msg_code  (r_msg_code),
        .i_rest_word (r_rest_word),
        .o_xlate     (xlate)
    );

    iht_csum u_csum (
        .i_action       (r_action),
        .i_msg_type     (r_msg_type),
        .i_msg_code     (r_msg_code),
        .i_rest_word    (r_rest_word),
        .i_old_checksum (r_old_checksum),
        .i_pseudo_sum   (r_pseudo_sum),
        .i_xlate        (xlate),
        .o_checksum     (n_checksum)
    );

    // dropped items report all-zero fields
    always_ff @(posedge i_clk) begin
        r_accepted      <= xlate.accepted;
        r_out_type      <= xlate.accepted ? xlate.msg_type : 8'd0;
        r_out_code      <= xlate.accepted ? xlate.msg_code : 8'd0;
        r_out_rest_word <= xlate.accepted ? xlate.rest_word : 32'd0;
        r_out_checksum  <= n_checksum;
    end

    assign o_strobe        = r_strobe;
    assign o_accepted      = r_accepted;
    assign o_out_type      = r_out_type;
    assign o_out_code      = r_out_code;
    assign o_out_rest_word = r_out_rest_word;
    assign o_out_checksum  = r_out_checksum;

endmodule

// File: test/icmp_header_translate_checker.sv
`timescale 1ns / 100ps

module icmp_header_translate_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_action,
    input  logic [7:0]  i_msg_type,
    input  logic [7:0]  i_msg_code,
    input  logic [31:0] i_rest_word,
    input  logic [15:0] i_old_checksum,
    input  logic [15:0] i_pseudo_sum,
    input  logic        i_strobe,
    input  logic        i_accepted,
    input  logic [7:0]  i_out_type,
    input  logic [7:0]  i_out_code,
    input  logic [31:0] i_out_rest_word,
    input  logic [15:0] i_out_checksum,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic        accepted;
        logic [7:0]  msg_type;
        logic [7:0]  msg_code;
        logic [31:0] rest_word;
        logic [15:0] checksum;
    } t_xlate_hdr;

    t_xlate_hdr header_q[$];

    function automatic logic [31:0] csum_swap_word(logic [31:0] acc, logic [15:0] was,
                                                   logic [15:0] now);
        if (was != now) return acc + {16'h0, ~was} + {16'h0, now};
        return acc;
    endfunction

    function automatic t_xlate_hdr translate_header(logic to_v4, logic [7:0] t, logic [7:0] c,
                                                    logic [31:0] rest, logic [15:0] old_ck,
                                                    logic [15:0] pseudo);
        t_xlate_hdr  res;
        logic        ok;
        logic [7:0]  nt;
        logic [7:0]  nc;
        logic [31:0] nr;
        logic [31:0] mtu;
        logic [31:0] acc;
        logic [7:0]  ptr;
        nt = t;
        nc = c;
        nr = rest;
        ok = 1'b1;
        if (to_v4 == iht_pkg::DIR_V4_TO_V6[0]) begin
            case (t)
                iht_pkg::V4_ECHO_REQUEST: nt = iht_pkg::V6_ECHO_REQUEST;
                iht_pkg::V4_ECHO_REPLY:   nt = iht_pkg::V6_ECHO_REPLY;
                iht_pkg::V4_TIME_EXCEED:  nt = iht_pkg::V6_TIME_EXCEED;
                iht_pkg::V4_DEST_UNREACH: begin
                    nt = iht_pkg::V6_DEST_UNREACH;
                    case (c)
                        iht_pkg::V4_IN_NET, iht_pkg::V4_IN_HOST, iht_pkg::V4_IN_SRC_ROUTE,
                        iht_pkg::V4_IN_NET_UNK, iht_pkg::V4_IN_HOST_UNK,
                        iht_pkg::V4_IN_ISOLATED, iht_pkg::V4_IN_NET_TOS,
                        iht_pkg::V4_IN_HOST_TOS: nc = iht_pkg::V6_UNR_NOROUTE;
                        iht_pkg::V4_IN_PORT: nc = iht_pkg::V6_UNR_PORT;
                        iht_pkg::V4_IN_NET_PROHIB, iht_pkg::V4_IN_HST_PROHIB,
                        iht_pkg::V4_IN_ADMIN, iht_pkg::V4_IN_PREC_VIOL:
                            nc = iht_pkg::V6_UNR_ADMIN;
                        iht_pkg::V4_IN_PROTO: begin
                            nt = iht_pkg::V6_PARAM_PROB;
                            nc = iht_pkg::V6_PP_NEXTHDR;
                            nr = iht_pkg::NEXTHDR_PTR;
                        end
                        iht_pkg::V4_IN_FRAG: begin
                            mtu = {16'h0, rest[15:0]} + {16'h0, iht_pkg::MTU_DELTA};
                            if (mtu < {15'h0, iht_pkg::MIN_V6_MTU})
                                mtu = {15'h0, iht_pkg::MIN_V6_MTU};
                            nt = iht_pkg::V6_PKT_TOO_BIG;
                            nc = iht_pkg::V6_PTB_CODE;
                            nr = mtu;
                        end
                        default: ok = 1'b0;
                    endcase
                end
                iht_pkg::V4_PARAM_PROB: begin
                    ptr = rest[31:24];
                    nt = iht_pkg::V6_PARAM_PROB;
                    nc = iht_pkg::V6_PP_HDR;
                    if (c != iht_pkg::V4_IN_PP_PTR && c != iht_pkg::V4_IN_PP_BADLEN) ok = 1'b0;
                    else if (ptr <= 8'd1) nr = {24'h0, ptr};
                    else if (ptr <= 8'd3) nr = 32'd4;
                    else if (ptr == 8'd8) nr = 32'd7;
                    else if (ptr == 8'd9) nr = 32'd6;
                    else if (ptr >= 8'd12 && ptr <= 8'd15) nr = 32'd8;
                    else if (ptr >= 8'd16 && ptr <= 8'd19) nr = 32'd24;
                    else ok = 1'b0;
                end
                default: ok = 1'b0;
            endcase
        end else begin
            case (t)
                iht_pkg::V6_ECHO_REQUEST: nt = iht_pkg::V4_ECHO_REQUEST;
                iht_pkg::V6_ECHO_REPLY:   nt = iht_pkg::V4_ECHO_REPLY;
                iht_pkg::V6_TIME_EXCEED:  nt = iht_pkg::V4_TIME_EXCEED;
                iht_pkg::V6_DEST_UNREACH: begin
                    nt = iht_pkg::V4_DEST_UNREACH;
                    case (c)
                        iht_pkg::V6_IN_NOROUTE, iht_pkg::V6_IN_SCOPE, iht_pkg::V6_IN_ADDR:
                            nc = iht_pkg::V4_UNR_HOST;
                        iht_pkg::V6_IN_ADMIN: nc = iht_pkg::V4_UNR_ADMIN;
                        iht_pkg::V6_IN_PORT:  nc = iht_pkg::V4_UNR_PORT;
                        default:              ok = 1'b0;
                    endcase
                end
                iht_pkg::V6_PKT_TOO_BIG: begin
                    mtu = rest - {16'h0, iht_pkg::MTU_DELTA};
                    if (mtu[31:16] != 16'h0) ok = 1'b0;
                    nt = iht_pkg::V4_DEST_UNREACH;
                    nc = iht_pkg::V4_UNR_FRAG;
                    nr = mtu;
                end
                iht_pkg::V6_PARAM_PROB: begin
                    if (c == iht_pkg::V6_PP_NEXTHDR) begin
                        nt = iht_pkg::V4_DEST_UNREACH;
                        nc = iht_pkg::V4_UNR_PROTO;
                        nr = 32'h0;
                    end else if (c != iht_pkg::V6_PP_HDR) begin
                        ok = 1'b0;
                    end else begin
                        // pointer moves from a 32-bit word into the top byte
                        nt = iht_pkg::V4_PARAM_PROB;
                        nc = iht_pkg::V4_PP_PTR;
                        if (rest <= 32'd1) ptr = rest[7:0];
                        else if (rest == 32'd4 || rest == 32'd5) ptr = 8'd2;
                        else if (rest == 32'd6) ptr = 8'd9;
                        else if (rest == 32'd7) ptr = 8'd8;
                        else if (rest >= 32'd8 && rest <= 32'd23) ptr = 8'd12;
                        else if (rest >= 32'd24 && rest <= 32'd39) ptr = 8'd16;
                        else begin
                            ok = 1'b0;
                            ptr = 8'h0;
                        end
                        nr = {ptr, 24'h0};
                    end
                end
                default: ok = 1'b0;
            endcase
        end

        if (!ok) return '0;
        // v4 to v6 folds the pseudo-header in, v6 to v4 takes it out
        acc = {16'h0, ~old_ck};
        acc = acc + (to_v4 ? {16'h0, ~pseudo} : {16'h0, pseudo});
        acc = csum_swap_word(acc, {t, c}, {nt, nc});
        acc = csum_swap_word(acc, rest[31:16], nr[31:16]);
        acc = csum_swap_word(acc, rest[15:0], nr[15:0]);
        acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
        acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
        res.accepted  = 1'b1;
        res.msg_type  = nt;
        res.msg_code  = nc;
        res.rest_word = nr;
        res.checksum  = ~acc[15:0];
        return res;
    endfunction

    function automatic string hdr_text(t_xlate_hdr h);
        return $sformatf("acc=%0d type=%0d code=%0d rest=%h csum=%h",
                         h.accepted, h.msg_type, h.msg_code, h.rest_word, h.checksum);
    endfunction

    task automatic report_fault(string msg);
        if (o_fail_count < REPORT_MAX) $display("%0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_xlate_hdr got;
        t_xlate_hdr want;
        if (!i_rst_n) begin
            header_q.delete();
        end else begin
            if (i_strobe) begin
                got = {i_accepted, i_out_type, i_out_code, i_out_rest_word, i_out_checksum};
                if (header_q.size() == 0) begin
                    report_fault({"result with no item pending: ", hdr_text(got)});
                end else begin
                    want = header_q.pop_front();
                    if (got.accepted !== want.accepted || got.msg_type !== want.msg_type ||
                        got.msg_code !== want.msg_code || got.rest_word !== want.rest_word ||
                        got.checksum !== want.checksum)
                        report_fault({"mismatch: expected ", hdr_text(want),
                                      " got ", hdr_text(got)});
                end
            end
            if (i_start && !i_busy)
                header_q.push_back(translate_header(i_action, i_msg_type, i_msg_code,
                                                    i_rest_word, i_old_checksum,
                                                    i_pseudo_sum));
        end
        o_pending = header_q.size();
    end

endmodule

// File: test/icmp_header_translate_tb.sv
`timescale 1ns / 100ps

module icmp_header_translate_tb;

    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 500;
    localparam int SETTLE_CYCLES = 4;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_action;
    logic [7:0]  i_msg_type;
    logic [7:0]  i_msg_code;
    logic [31:0] i_rest_word;
    logic [15:0] i_old_checksum;
    logic [15:0] i_pseudo_sum;
    logic        o_strobe;
    logic        o_accepted;
    logic [7:0]  o_out_type;
    logic [7:0]  o_out_code;
    logic [31:0] o_out_rest_word;
    logic [15:0] o_out_checksum;

    int   fail_count;
    int   pending;
    int   stall_cycles = 0;
    int   quiet_left;
    logic took_item = 1'b0;

    always #1 i_clk = ~i_clk;

    icmp_header_translate u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_msg_type     (i_msg_type),
        .i_msg_code     (i_msg_code),
        .i_rest_word    (i_rest_word),
        .i_old_checksum (i_old_checksum),
        .i_pseudo_sum   (i_pseudo_sum),
        .o_strobe       (o_strobe),
        .o_accepted     (o_accepted),
        .o_out_type     (o_out_type),
        .o_out_code     (o_out_code),
        .o_out_rest_word(o_out_rest_word),
        .o_out_checksum (o_out_checksum)
    );

    icmp_header_translate_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_action       (i_action),
        .i_msg_type     (i_msg_type),
        .i_msg_code     (i_msg_code),
        .i_rest_word    (i_rest_word),
        .i_old_checksum (i_old_checksum),
        .i_pseudo_sum   (i_pseudo_sum),
        .i_strobe       (o_strobe),
        .i_accepted     (o_accepted),
        .i_out_type     (o_out_type),
        .i_out_code     (o_out_code),
        .i_out_rest_word(o_out_rest_word),
        .i_out_checksum (o_out_checksum),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always @(posedge i_clk) begin
        took_item <= i_rst_n && start && !busy;
        if ((i_rst_n && start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_item(logic act, logic [7:0] t, logic [7:0] c, logic [31:0] rest,
                             logic [15:0] ck, logic [15:0] ps);
        int gap;
        if (quiet_left > 0) begin
            quiet_left--;
            gap = 0;
        end else if ($urandom_range(0, 7) == 0) begin
            quiet_left = $urandom_range(10, 30);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 11);
        end
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action       = act;
        i_msg_type     = t;
        i_msg_code     = c;
        i_rest_word    = rest;
        i_old_checksum = ck;
        i_pseudo_sum   = ps;
        start          = 1'b1;
        do @(negedge i_clk); while (!took_item);
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic send_random_item();
        logic        act;
        logic [7:0]  t;
        logic [7:0]  c;
        logic [31:0] rest;
        logic [15:0] ck;
        logic [15:0] ps;
        act  = 1'($urandom_range(0, 1));
        rest = $urandom();
        c    = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 15));
        ck   = 16'($urandom_range(0, 65535));
        ps   = ($urandom_range(0, 15) == 0) ? {16{ck[0]}} : 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 9) >= 8) begin
            t = 8'($urandom_range(0, 255));
        end else if (act == iht_pkg::DIR_V4_TO_V6[0]) begin
            case ($urandom_range(0, 4))
                0: t = iht_pkg::V4_ECHO_REQUEST;
                1: t = iht_pkg::V4_ECHO_REPLY;
                2: t = iht_pkg::V4_DEST_UNREACH;
                3: t = iht_pkg::V4_TIME_EXCEED;
                default: t = iht_pkg::V4_PARAM_PROB;
            endcase
        end else begin
            case ($urandom_range(0, 5))
                0: t = iht_pkg::V6_ECHO_REQUEST;
                1: t = iht_pkg::V6_ECHO_REPLY;
                2: t = iht_pkg::V6_DEST_UNREACH;
                3: t = iht_pkg::V6_PKT_TOO_BIG;
                4: t = iht_pkg::V6_TIME_EXCEED;
                default: t = iht_pkg::V6_PARAM_PROB;
            endcase
        end
        // steer the rest word into the interesting ranges of each type
        if (act == iht_pkg::DIR_V4_TO_V6[0]) begin
            if (t == iht_pkg::V4_PARAM_PROB && $urandom_range(0, 3) != 0)
                rest[31:24] = 8'($urandom_range(0, 24));
            if (t == iht_pkg::V4_DEST_UNREACH && $urandom_range(0, 1) == 0)
                rest[15:0] = 16'($urandom_range(0, 1400));
        end else begin
            if (t == iht_pkg::V6_PARAM_PROB) begin
                if ($urandom_range(0, 1) == 0) c = 8'($urandom_range(0, 2));
                if ($urandom_range(0, 3) != 0) rest = $urandom_range(0, 45);
            end
            if (t == iht_pkg::V6_PKT_TOO_BIG) begin
                case ($urandom_range(0, 2))
                    0: rest = $urandom_range(0, 40);
                    1: rest = $urandom_range(1200, 70000);
                    default: ;
                endcase
            end
        end
        send_item(act, t, c, rest, ck, ps);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_action       = 1'b0;
        i_msg_type     = 8'h0;
        i_msg_code     = 8'h0;
        i_rest_word    = 32'h0;
        i_old_checksum = 16'h0;
        i_pseudo_sum   = 16'h0;
        quiet_left     = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // v4 to v6: every type, unreachable code groups, MTU floor and top, pointers
        send_item(1'b0, iht_pkg::V4_ECHO_REQUEST, 8'hff, 32'hffffffff, 16'h0000, 16'hffff);
        send_item(1'b0, iht_pkg::V4_ECHO_REPLY, 8'h00, 32'h00000000, 16'hffff, 16'h0000);
        send_item(1'b0, iht_pkg::V4_DEST_UNREACH, iht_pkg::V4_IN_NET, 32'h12345678,
                  16'h1234, 16'h8001);
        send_item(1'b0, iht_pkg::V4_DEST_UNREACH, iht_pkg::V4_IN_PORT, 32'hdeadbeef,
                  16'h0f0f, 16'hf0f0);
        send_item(1'b0, iht_pkg::V4_DEST_UNREACH, iht_pkg::V4_IN_ADMIN, 32'h0,
                  16'haaaa, 16'h5555);
        send_item(1'b0, iht_pkg::V4_DEST_UNREACH, iht_pkg::V4_IN_PROTO, 32'hffffffff,
                  16'h0001, 16'hfffe);
        send_item(1'b0, iht_pkg::V4_DEST_UNREACH, iht_pkg::V4_IN_FRAG, 32'hffff0000,
                  16'h7fff, 16'h8000);
        send_item(1'b0, iht_pkg::V4_DEST_UNREACH, iht_pkg::V4_IN_FRAG, 32'h0000ffff,
                  16'h4321, 16'h0000);
        send_item(1'b0, iht_pkg::V4_DEST_UNREACH, 8'd14, 32'h0, 16'h1111, 16'h2222);
        send_item(1'b0, iht_pkg::V4_TIME_EXCEED, 8'd1, 32'h0, 16'hffff, 16'hffff);
        send_item(1'b0, iht_pkg::V4_PARAM_PROB, iht_pkg::V4_IN_PP_PTR, 32'h03abcdef,
                  16'h0000, 16'h0000);
        send_item(1'b0, iht_pkg::V4_PARAM_PROB, iht_pkg::V4_IN_PP_BADLEN, 32'h13000000,
                  16'h5a5a, 16'ha5a5);
        send_item(1'b0, iht_pkg::V4_PARAM_PROB, iht_pkg::V4_IN_PP_PTR, 32'h14000000,
                  16'h1000, 16'h0100);
        send_item(1'b0, iht_pkg::V4_PARAM_PROB, 8'd1, 32'h00000000, 16'h1000, 16'h0100);
        send_item(1'b0, 8'd255, 8'd255, 32'hffffffff, 16'hffff, 16'hffff);
        // v6 to v4: echo, unreachable, MTU wrap and top, pointers, next header
        send_item(1'b1, iht_pkg::V6_ECHO_REQUEST, 8'd0, 32'hcafef00d, 16'h0000, 16'hffff);
        send_item(1'b1, iht_pkg::V6_ECHO_REPLY, 8'd7, 32'h00010002, 16'hffff, 16'h0000);
        send_item(1'b1, iht_pkg::V6_DEST_UNREACH, iht_pkg::V6_IN_PORT, 32'h0,
                  16'h2468, 16'h1357);
        send_item(1'b1, iht_pkg::V6_DEST_UNREACH, 8'd5, 32'h0, 16'h2468, 16'h1357);
        send_item(1'b1, iht_pkg::V6_PKT_TOO_BIG, 8'd0, 32'd20, 16'h8000, 16'h7fff);
        send_item(1'b1, iht_pkg::V6_PKT_TOO_BIG, 8'd0, 32'd19, 16'h8000, 16'h7fff);
        send_item(1'b1, iht_pkg::V6_PKT_TOO_BIG, 8'd0, 32'h00010013, 16'h0102, 16'h0304);
        send_item(1'b1, iht_pkg::V6_PARAM_PROB, iht_pkg::V6_PP_HDR, 32'd39,
                  16'h0000, 16'h0001);
        send_item(1'b1, iht_pkg::V6_PARAM_PROB, iht_pkg::V6_PP_HDR, 32'd2,
                  16'h0000, 16'h0001);
        send_item(1'b1, iht_pkg::V6_PARAM_PROB, iht_pkg::V6_PP_NEXTHDR, 32'hffffffff,
                  16'hfffe, 16'hffff);
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_random_item();
            if ($urandom_range(0, 99) == 0) wait_drained();
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
